/* design/rvcs_pkg.sv */
`default_nettype none

package rvcs_pkg;

    // Architectural widths
    localparam int XLEN       = 64;
    localparam int PC_W       = 32;
    localparam int REG_IDX_W  = 5;
    localparam int NREGS      = 32;
    localparam int MEM_ADDR_W = 8;
    localparam int LANES      = 8;

    typedef logic [XLEN-1:0]       word_t;
    typedef logic [PC_W-1:0]       pc_t;
    typedef logic [REG_IDX_W-1:0]  reg_idx_t;
    typedef logic [MEM_ADDR_W-1:0] maddr_t;
    typedef logic [2:0]            lane_t;
    typedef logic [6:0]            opcode_t;
    typedef logic [2:0]            funct3_t;
    typedef logic [6:0]            funct7_t;

    // Major opcodes
    localparam opcode_t OP_R    = 7'd51;
    localparam opcode_t OP_I    = 7'd19;
    localparam opcode_t OP_LD   = 7'd3;
    localparam opcode_t OP_JALR = 7'd103;
    localparam opcode_t OP_SD   = 7'd35;
    localparam opcode_t OP_BR   = 7'd99;
    localparam opcode_t OP_JAL  = 7'd111;

    // funct7 codes
    localparam funct7_t F7_ZERO = 7'b0000000;
    localparam funct7_t F7_ALT  = 7'b0100000;

    // ALU funct3 codes
    localparam funct3_t F3_ADD = 3'd0;
    localparam funct3_t F3_SLL = 3'd1;
    localparam funct3_t F3_SLT = 3'd2;
    localparam funct3_t F3_XOR = 3'd4;
    localparam funct3_t F3_SRL = 3'd5;
    localparam funct3_t F3_OR  = 3'd6;
    localparam funct3_t F3_AND = 3'd7;

    // Memory, jump and branch funct3 codes
    localparam funct3_t F3_DW   = 3'd3;
    localparam funct3_t F3_JALR = 3'd0;
    localparam funct3_t F3_BEQ  = 3'd0;
    localparam funct3_t F3_BNE  = 3'd1;
    localparam funct3_t F3_BLT  = 3'd4;
    localparam funct3_t F3_BGE  = 3'd5;

    // One retired instruction as reported on the result channel
    typedef struct packed {
        pc_t      instr_pc;
        pc_t      next_pc;
        logic     reg_written;
        reg_idx_t dest_reg;
        word_t    write_value;
        logic     mem_written;
        maddr_t   mem_address;
        logic     illegal_op;
        logic     halted;
    } result_t;

endpackage

`default_nettype wire

/* design/rv64i_subset_core_step_top.sv */
`default_nettype none

// Channel   Handshake             Payload
// -------   -------------------   ---------------------------------------------
// in        in_valid / in_stall   instruction_word
// out       out_valid / out_stall instr_pc, next_pc, reg_written, dest_reg,
//                                 write_value, mem_written, mem_address,
//                                 illegal_op, halted
// config    config_write_enable   config_write_data (last_program_address)
//
// One instruction retires per cycle while out_stall allows; ld adds a read phase
// in the execute register: the data memory banks register read data at rs1 + imm.
// The register file is read as an instruction is taken in; the value of the
// instruction retiring on that same edge is bypassed.
// After reset a clearing pass zeroes the data memory row by row, DATA_BYTES/8 rows
// (32 at the default size), while in_stall is held high.
// The input side keeps taking transactions while a result waits under out_stall,
// until the execute register is also full.
// DATA_BYTES must be a power of two of at least 64.

module rv64i_subset_core_step_top
    import rvcs_pkg::*;
#(
    parameter int DATA_BYTES = 256
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  config_write_enable,
    input  wire logic [PC_W-1:0]       config_write_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [31:0]           instruction_word,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [PC_W-1:0]            instr_pc,
    output logic [PC_W-1:0]            next_pc,
    output logic                       reg_written,
    output logic [REG_IDX_W-1:0]       dest_reg,
    output logic signed [XLEN-1:0]     write_value,
    output logic                       mem_written,
    output logic [MEM_ADDR_W-1:0]      mem_address,
    output logic                       illegal_op,
    output logic                       halted
);

    localparam int ADDR_W = $clog2(DATA_BYTES);
    localparam int ROW_W  = ADDR_W - 3;
    localparam int ROWS   = DATA_BYTES / LANES;

    typedef logic [ADDR_W-1:0] daddr_t;
    typedef logic [ROW_W-1:0]  row_t;

    // Control state
    logic             s1_valid_reg;
    logic             ld_phase_reg;
    logic             res_valid_reg;
    pc_t              pc_reg;
    pc_t              last_addr_reg;
    logic [NREGS-1:0] rf_valid_reg;
    logic             clr_busy_reg;
    row_t             clr_row_reg;
    logic             fwd1_reg;
    logic             fwd2_reg;

    // Payload state
    logic [31:0]      s1_ins_reg;
    word_t            rd1_reg;
    word_t            rd2_reg;
    logic             rv1_reg;
    logic             rv2_reg;
    word_t            fwd_val_reg;
    result_t          res_reg;
    logic [7:0]       bank_q_reg [LANES];

    // Storage
    word_t            rf_mem   [NREGS];
    logic [7:0]       bank_mem [LANES][ROWS];

    // Execute-stage signals
    opcode_t          op;
    reg_idx_t         rd;
    funct3_t          f3;
    funct7_t          f7;
    word_t            a;
    word_t            b;
    word_t            imm_i;
    word_t            imm_s;
    word_t            imm_b;
    word_t            imm_j;
    word_t            b_alu;
    word_t            alu_val;
    logic             alu_ok;
    word_t            ea;
    daddr_t           ea_addr;
    lane_t            lo;
    row_t             base_row;
    row_t             bank_row   [LANES];
    logic [7:0]       bank_wdata [LANES];
    word_t            ld_data;
    logic             is_ld;
    logic             ok;
    logic             wr;
    logic             mw;
    word_t            val;
    daddr_t           maddr;
    pc_t              pc_plus4;
    pc_t              next;
    logic             take;
    logic             rf_we;
    logic             exec;
    logic             ld_issue;
    logic             in_accept;
    reg_idx_t         rs1_in;
    reg_idx_t         rs2_in;
    result_t          res_next;

    // Handshake
    assign in_accept = in_valid && !in_stall;
    assign rs1_in    = instruction_word[19:15];
    assign rs2_in    = instruction_word[24:20];

    // Field split and operands with bypass
    assign op = s1_ins_reg[6:0];
    assign rd = s1_ins_reg[11:7];
    assign f3 = s1_ins_reg[14:12];
    assign f7 = s1_ins_reg[31:25];

    assign a = fwd1_reg ? fwd_val_reg : (rv1_reg ? rd1_reg : '0);
    assign b = fwd2_reg ? fwd_val_reg : (rv2_reg ? rd2_reg : '0);

    // Immediates
    assign imm_i = {{52{s1_ins_reg[31]}}, s1_ins_reg[31:20]};
    assign imm_s = {{52{s1_ins_reg[31]}}, s1_ins_reg[31:25], s1_ins_reg[11:7]};
    assign imm_b = {{51{s1_ins_reg[31]}}, s1_ins_reg[31], s1_ins_reg[7],
                    s1_ins_reg[30:25], s1_ins_reg[11:8], 1'b0};
    assign imm_j = {{43{s1_ins_reg[31]}}, s1_ins_reg[31], s1_ins_reg[19:12],
                    s1_ins_reg[20], s1_ins_reg[30:21], 1'b0};

    // ALU
    assign b_alu = (op == OP_I) ? imm_i : b;

    always_comb
    begin
        alu_ok  = 1'b1;
        alu_val = '0;
        unique case (f3)
            F3_ADD:
            begin
                if ((op == OP_R) && (f7 == F7_ALT))
                    alu_val = a - b_alu;
                else
                    alu_val = a + b_alu;
            end
            F3_SLL: alu_val = a << b_alu[5:0];
            F3_SLT: alu_val = {63'd0, ($signed(a) < $signed(b_alu))};
            F3_XOR: alu_val = a ^ b_alu;
            F3_SRL: alu_val = a >> b_alu[5:0];
            F3_OR:  alu_val = a | b_alu;
            F3_AND: alu_val = a & b_alu;
            default: alu_ok = 1'b0;
        endcase
    end

    // Effective address, wrapped to the data memory
    assign ea       = a + ((op == OP_SD) ? imm_s : imm_i);
    assign ea_addr  = ea[ADDR_W-1:0];
    assign lo       = ea_addr[2:0];
    assign base_row = ea_addr[ADDR_W-1:3];

    // Per-bank row and store byte: lanes below the start byte spill into the next row
    always_comb
    begin
        lane_t wsel;
        wsel = '0;
        for (int k = 0; k < LANES; k++)
        begin
            bank_row[k]   = base_row + ((lane_t'(k) < lo) ? row_t'(1) : row_t'(0));
            wsel          = lane_t'(k) - lo;
            bank_wdata[k] = b[wsel*8 +: 8];
        end
    end

    // Gather load bytes from the banks in address order
    always_comb
    begin
        lane_t rsel;
        rsel    = '0;
        ld_data = '0;
        for (int i = 0; i < LANES; i++)
        begin
            rsel              = lo + lane_t'(i);
            ld_data[i*8 +: 8] = bank_q_reg[rsel];
        end
    end

    // Decode and execute
    assign pc_plus4 = pc_reg + 32'd4;

    always_comb
    begin
        ok    = 1'b1;
        wr    = 1'b0;
        mw    = 1'b0;
        val   = '0;
        maddr = '0;
        take  = 1'b0;
        is_ld = 1'b0;
        next  = pc_plus4;
        unique case (op)
            OP_R:
            begin
                if ((f7 == F7_ZERO) || ((f7 == F7_ALT) && (f3 == F3_ADD)))
                begin
                    val = alu_val;
                    ok  = alu_ok;
                    wr  = alu_ok;
                end
                else
                    ok = 1'b0;
            end
            OP_I:
            begin
                if (((f3 == F3_SLL) || (f3 == F3_SRL)) && (s1_ins_reg[31:26] != 6'd0))
                    ok = 1'b0;
                else
                begin
                    val = alu_val;
                    ok  = alu_ok;
                    wr  = alu_ok;
                end
            end
            OP_LD:
            begin
                if (f3 == F3_DW)
                begin
                    is_ld = 1'b1;
                    maddr = ea_addr;
                    val   = ld_data;
                    wr    = 1'b1;
                end
                else
                    ok = 1'b0;
            end
            OP_SD:
            begin
                if (f3 == F3_DW)
                begin
                    maddr = ea_addr;
                    mw    = 1'b1;
                end
                else
                    ok = 1'b0;
            end
            OP_BR:
            begin
                unique case (f3)
                    F3_BEQ: take = (a == b);
                    F3_BNE: take = (a != b);
                    F3_BLT: take = ($signed(a) < $signed(b));
                    F3_BGE: take = !($signed(a) < $signed(b));
                    default: ok = 1'b0;
                endcase
                if (take)
                    next = pc_reg + imm_b[PC_W-1:0];
            end
            OP_JAL:
            begin
                val  = {32'd0, pc_plus4};
                wr   = 1'b1;
                next = pc_reg + imm_j[PC_W-1:0];
            end
            OP_JALR:
            begin
                if (f3 == F3_JALR)
                begin
                    val  = {32'd0, pc_plus4};
                    wr   = 1'b1;
                    next = (a[PC_W-1:0] + imm_i[PC_W-1:0]) & ~32'd1;
                end
                else
                    ok = 1'b0;
            end
            default: ok = 1'b0;
        endcase

        // Drop every effect of an unsupported encoding
        if (!ok)
        begin
            wr    = 1'b0;
            mw    = 1'b0;
            val   = '0;
            maddr = '0;
            next  = pc_plus4;
        end
        // Destination x0 writes nothing
        if (rd == '0)
            wr = 1'b0;
    end

    // Stage control
    assign exec     = s1_valid_reg && (!is_ld || ld_phase_reg) && (!res_valid_reg || !out_stall);
    assign ld_issue = s1_valid_reg && is_ld && !ld_phase_reg;
    assign rf_we    = exec && wr;
    assign in_stall = clr_busy_reg || (s1_valid_reg && !exec);

    // Result of the retiring instruction
    always_comb
    begin
        res_next.instr_pc    = pc_reg;
        res_next.next_pc     = next;
        res_next.reg_written = wr;
        res_next.dest_reg    = wr ? rd : '0;
        res_next.write_value = wr ? val : '0;
        res_next.mem_written = mw;
        res_next.mem_address = maddr_t'(maddr);
        res_next.illegal_op  = !ok;
        res_next.halted      = (next > last_addr_reg);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            ld_phase_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            pc_reg        <= '0;
            last_addr_reg <= '0;
            rf_valid_reg  <= '0;
            clr_busy_reg  <= 1'b1;
            clr_row_reg   <= '0;
            fwd1_reg      <= 1'b0;
            fwd2_reg      <= 1'b0;
        end
        else
        begin
            // Configuration write
            if (config_write_enable)
                last_addr_reg <= config_write_data;

            // Advance the data memory clearing pass
            if (clr_busy_reg)
            begin
                clr_row_reg <= clr_row_reg + row_t'(1);
                if (clr_row_reg == row_t'(ROWS - 1))
                    clr_busy_reg <= 1'b0;
            end

            // Execute register occupancy and load phase
            if (in_accept)
            begin
                s1_valid_reg <= 1'b1;
                fwd1_reg     <= rf_we && (rd == rs1_in);
                fwd2_reg     <= rf_we && (rd == rs2_in);
            end
            else if (exec)
                s1_valid_reg <= 1'b0;

            if (ld_issue)
                ld_phase_reg <= 1'b1;
            else if (exec)
                ld_phase_reg <= 1'b0;

            // Result register occupancy
            if (exec)
                res_valid_reg <= 1'b1;
            else if (!out_stall)
                res_valid_reg <= 1'b0;

            // Retire: PC and register written marks
            if (exec)
                pc_reg <= next;
            if (rf_we)
                rf_valid_reg[rd] <= 1'b1;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_ins_reg  <= instruction_word;
            rv1_reg     <= rf_valid_reg[rs1_in];
            rv2_reg     <= rf_valid_reg[rs2_in];
            fwd_val_reg <= val;
        end
        if (exec)
            res_reg <= res_next;
    end

    // Register file: one write, two registered reads
    always_ff @(posedge clk)
    begin
        if (rf_we)
            rf_mem[rd] <= val;
        if (in_accept)
        begin
            rd1_reg <= rf_mem[rs1_in];
            rd2_reg <= rf_mem[rs2_in];
        end
    end

    // Data memory: eight byte banks, clear, store and registered load read
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < LANES; k++)
        begin
            if (clr_busy_reg)
                bank_mem[k][clr_row_reg] <= 8'd0;
            else if (exec && mw)
                bank_mem[k][bank_row[k]] <= bank_wdata[k];
            if (ld_issue)
                bank_q_reg[k] <= bank_mem[k][bank_row[k]];
        end
    end

    // Output ports
    assign out_valid   = res_valid_reg;
    assign instr_pc    = res_reg.instr_pc;
    assign next_pc     = res_reg.next_pc;
    assign reg_written = res_reg.reg_written;
    assign dest_reg    = res_reg.dest_reg;
    assign write_value = res_reg.write_value;
    assign mem_written = res_reg.mem_written;
    assign mem_address = res_reg.mem_address;
    assign illegal_op  = res_reg.illegal_op;
    assign halted      = res_reg.halted;

    // Assertions
    a_x0_never_marked: assert property (@(posedge clk) disable iff (!rst_n)
        !rf_valid_reg[0])
        else $error("x0 marked as written");

    a_ld_phase_owner: assert property (@(posedge clk) disable iff (!rst_n)
        ld_phase_reg |-> (s1_valid_reg && is_ld))
        else $error("load phase set without a load in execute");

    a_illegal_no_effect: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && illegal_op) |->
            (!reg_written && !mem_written && (next_pc == instr_pc + 32'd4)))
        else $error("illegal instruction had an effect");

    a_pc_follows_result: assert property (@(posedge clk) disable iff (!rst_n)
        exec |=> (out_valid && (pc_reg == next_pc)))
        else $error("PC does not match reported next PC");

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |=> !ld_issue && !(exec && mw))
        else $error("memory access during clearing pass");

endmodule

`default_nettype wire
